// ----- rtl/bba_pkg.sv -----
package bba_pkg;

    // Map geometry
    localparam int MAX_BLOCKS  = 4096;
    localparam int MAX_REQUEST = 32;
    localparam int WORD_W      = 32;
    localparam int WORD_NUM    = MAX_BLOCKS / WORD_W;
    localparam int WORD_AW     = $clog2(WORD_NUM);
    localparam int BIT_W       = $clog2(WORD_W);

    // Field widths
    localparam int BLK_W  = 12;
    localparam int PTR_W  = 13;
    localparam int CNT_W  = 6;
    localparam int BYTE_W = 8;
    localparam int ACT_W  = 3;
    localparam int ST_W   = 2;

    // Stream data widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    // Result field offsets in m_tdata
    localparam int OUT_USED_LSB = BLK_W;
    localparam int OUT_ST_LSB   = BLK_W + 1;
    localparam int OUT_REM_LSB  = BLK_W + 1 + ST_W;

    localparam logic [PTR_W-1:0] MAX_BLOCKS_P  = PTR_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] MAX_REQUEST_C = CNT_W'(MAX_REQUEST);

    typedef enum logic [ACT_W-1:0] {
        ACT_QUERY      = 3'd0,
        ACT_ALLOC_ONE  = 3'd1,
        ACT_ALLOC_MANY = 3'd2,
        ACT_OCCUPY     = 3'd3,
        ACT_LOAD_BYTE  = 3'd4,
        ACT_SET_PTR    = 3'd5
    } action_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_RANGE    = 2'd2,
        ST_CONFLICT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_SCAN,
        S_QUERY,
        S_LOAD,
        S_OCC_LO,
        S_OCC_HI,
        S_OCC_WR,
        S_DONE
    } state_t;

    // Find-first-free result for one map word
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } scan_res_t;

endpackage

// ----- rtl/bba_map_ram.sv -----
module bba_map_ram
    import bba_pkg::*;
(
    input  logic               aclk,
    input  logic               we,
    input  logic [WORD_AW-1:0] waddr,
    input  logic [WORD_W-1:0]  wdata,
    input  logic               re,
    input  logic [WORD_AW-1:0] raddr,
    output logic [WORD_W-1:0]  q
);

    logic [WORD_W-1:0] mem [WORD_NUM];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            q <= mem[raddr];
        end
    end

endmodule

// ----- rtl/bba_word_scan.sv -----
module bba_word_scan
    import bba_pkg::*;
(
    input  logic [WORD_W-1:0]  word,
    input  logic [WORD_AW-1:0] word_idx,
    input  logic [BIT_W-1:0]   off,
    input  logic [PTR_W-1:0]   total,
    output scan_res_t          res
);

    logic [PTR_W-1:0]  lim;
    logic [WORD_W-1:0] free;

    // Blocks left below the total, counted from this word's base
    assign lim = total - {1'b0, word_idx, {BIT_W{1'b0}}};

    // Mark free bits at or above the offset and below the total
    always_comb begin
        for (int j = 0; j < WORD_W; j++) begin
            free[j] = !word[j] && (BIT_W'(j) >= off) && (lim > PTR_W'(j));
        end
    end

    // Pick the lowest free bit
    always_comb begin
        res.found = |free;
        res.idx   = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (free[j]) begin
                res.idx = BIT_W'(j);
            end
        end
    end

endmodule

// ----- rtl/bitmap_block_allocator.sv -----
// Bitmap next-fit block allocator.
// Requests enter on s_t* (s_tuser = action, s_tdata = block, count, byte
// value); results leave on m_t*, with m_tlast on the final result of each
// request. The used bits live in a 128 x 32 word memory; a next-fit pointer
// picks where allocation scans start. One find-first-free unit examines one
// map word per cycle, and waits while a found block cannot be sent.
// After reset the block sweeps the memory to zero, one word a cycle, through
// all 128 words with s_tready low; cfg_we may write total_blocks at any time
// the block is idle, reset value 4096.
// Set pointer and unknown actions go straight to the closing result; query,
// load byte, occupy range and allocation first read the map word (occupy
// range also the next one); allocation then scans up to 128 map words and
// grants up to 32 blocks. One request is worked on at a time; s_tready is
// high only between requests.
// m_t* is a registered output. When the receiver stalls, the pending result
// holds and the scan waits before emitting the next one.
module bitmap_block_allocator
    import bba_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [PTR_W-1:0]      cfg_wdata,   // total_blocks
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,     // block[11:0], count[17:12], byte_value[25:18]
    input  logic [ACT_W-1:0]      s_tuser,     // action[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,     // result_block[11:0], used_bit[12],
                                               // status[14:13], remaining[20:15]
    output logic                  m_tlast
);

    state_t                state_reg, state_next;
    logic [WORD_AW-1:0]    clr_reg, clr_next;
    action_t               act_reg, act_next;
    logic [BLK_W-1:0]      blk_reg, blk_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    logic [PTR_W-1:0]      total_reg;
    logic [WORD_W-1:0]     wrd_reg, wrd_next;
    logic [WORD_AW-1:0]    w_reg, w_next;
    logic [BIT_W-1:0]      off_reg, off_next;
    logic [CNT_W-1:0]      remain_reg, remain_next;
    logic                  fresh_reg, fresh_next;
    logic                  res_used_reg, res_used_next;
    status_t               res_st_reg, res_st_next;
    logic [CNT_W-1:0]      res_rem_reg, res_rem_next;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  m_tlast_reg;

    logic                  ram_we;
    logic [WORD_AW-1:0]    ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [WORD_AW-1:0]    ram_raddr;
    logic [WORD_W-1:0]     ram_q;

    logic                  emit_valid;
    logic [BLK_W-1:0]      emit_blk;
    logic                  emit_used;
    status_t               emit_st;
    logic [CNT_W-1:0]      emit_rem;
    logic                  emit_last;
    logic                  out_free;

    logic [PTR_W-1:0]      eff_total;
    logic [PTR_W-1:0]      ptr_fix;
    logic [BLK_W-1:0]      in_blk;
    logic [WORD_W-1:0]     cur_word;
    scan_res_t             scan;
    logic [BLK_W-1:0]      grant_blk;
    logic [WORD_W-1:0]     grant_word;
    logic [PTR_W-1:0]      next_base;
    logic [WORD_W-1:0]     run_ones;
    logic [2*WORD_W-1:0]   occ_mask;
    logic [PTR_W-1:0]      occ_end;
    logic [WORD_W-1:0]     load_word;

    bba_map_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .q     (ram_q)
    );

    bba_word_scan u_scan (
        .word     (cur_word),
        .word_idx (w_reg),
        .off      (off_reg),
        .total    (eff_total),
        .res      (scan)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign in_blk    = s_tdata[BLK_W-1:0];

    // Scans stop at the smaller of the register and the map size
    assign eff_total = (total_reg > MAX_BLOCKS_P) ? MAX_BLOCKS_P : total_reg;
    assign ptr_fix   = (ptr_reg >= eff_total) ? PTR_W'(1) : ptr_reg;

    // Scan datapath
    assign cur_word   = fresh_reg ? ram_q : wrd_reg;
    assign grant_blk  = {w_reg, scan.idx};
    assign grant_word = cur_word | (WORD_W'(1) << scan.idx);
    assign next_base  = {({1'b0, w_reg} + (WORD_AW + 1)'(1)), {BIT_W{1'b0}}};

    // Occupy range mask over two adjacent words
    assign run_ones = WORD_W'(((WORD_W + 1)'(1) << cnt_reg) - (WORD_W + 1)'(1));
    assign occ_mask = {{WORD_W{1'b0}}, run_ones} << blk_reg[BIT_W-1:0];
    assign occ_end  = {1'b0, blk_reg} + PTR_W'(cnt_reg);

    // Replace one byte lane for load byte
    always_comb begin
        for (int l = 0; l < WORD_W / BYTE_W; l++) begin
            load_word[l*BYTE_W +: BYTE_W] =
                (blk_reg[BIT_W-1:3] == (BIT_W - 3)'(l)) ? byte_reg
                                                         : ram_q[l*BYTE_W +: BYTE_W];
        end
    end

    // State and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            ptr_reg   <= '0;
            total_reg <= MAX_BLOCKS_P;
            fresh_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ptr_reg   <= ptr_next;
            fresh_reg <= fresh_next;
            if (cfg_we) begin
                total_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        blk_reg      <= blk_next;
        cnt_reg      <= cnt_next;
        byte_reg     <= byte_next;
        wrd_reg      <= wrd_next;
        w_reg        <= w_next;
        off_reg      <= off_next;
        remain_reg   <= remain_next;
        res_used_reg <= res_used_next;
        res_st_reg   <= res_st_next;
        res_rem_reg  <= res_rem_next;
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        act_next      = act_reg;
        blk_next      = blk_reg;
        cnt_next      = cnt_reg;
        byte_next     = byte_reg;
        ptr_next      = ptr_reg;
        wrd_next      = wrd_reg;
        w_next        = w_reg;
        off_next      = off_reg;
        remain_next   = remain_reg;
        fresh_next    = fresh_reg;
        res_used_next = res_used_reg;
        res_st_next   = res_st_reg;
        res_rem_next  = res_rem_reg;
        ram_we        = 1'b0;
        ram_waddr     = w_reg;
        ram_wdata     = cur_word;
        ram_re        = 1'b0;
        ram_raddr     = blk_reg[BLK_W-1:BIT_W];
        emit_valid    = 1'b0;
        emit_blk      = '0;
        emit_used     = 1'b0;
        emit_st       = ST_OK;
        emit_rem      = '0;
        emit_last     = 1'b1;

        case (state_reg)
            S_CLEAR: begin
                // Sweep the map to zero
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + WORD_AW'(1);
                if (clr_reg == WORD_AW'(WORD_NUM - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_tvalid) begin
                    // Latch the request and fetch its map word
                    act_next      = action_t'(s_tuser);
                    blk_next      = in_blk;
                    cnt_next      = s_tdata[BLK_W +: CNT_W];
                    byte_next     = s_tdata[BLK_W + CNT_W +: BYTE_W];
                    ram_re        = 1'b1;
                    ram_raddr     = in_blk[BLK_W-1:BIT_W];
                    res_used_next = 1'b0;
                    res_st_next   = ST_OK;
                    res_rem_next  = '0;
                    case (action_t'(s_tuser))
                        ACT_QUERY:      state_next = S_QUERY;
                        ACT_ALLOC_ONE:  state_next = S_ALLOC;
                        ACT_ALLOC_MANY: state_next = S_ALLOC;
                        ACT_OCCUPY:     state_next = S_OCC_LO;
                        ACT_LOAD_BYTE:  state_next = S_LOAD;
                        ACT_SET_PTR: begin
                            ptr_next   = {1'b0, in_blk};
                            state_next = S_DONE;
                        end
                        default: begin
                            res_st_next = ST_RANGE;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end

            S_QUERY: begin
                if ({1'b0, blk_reg} >= MAX_BLOCKS_P) begin
                    res_st_next = ST_RANGE;
                end else begin
                    res_used_next = ram_q[blk_reg[BIT_W-1:0]];
                end
                state_next = S_DONE;
            end

            S_LOAD: begin
                ram_we     = 1'b1;
                ram_waddr  = blk_reg[BLK_W-1:BIT_W];
                ram_wdata  = load_word;
                state_next = S_DONE;
            end

            S_ALLOC: begin
                if (act_reg == ACT_ALLOC_MANY && cnt_reg > MAX_REQUEST_C) begin
                    res_st_next = ST_RANGE;
                    state_next  = S_DONE;
                end else begin
                    // Pull the pointer back to 1 when it reached or ran past the total
                    ptr_next = ptr_fix;
                    if (act_reg == ACT_ALLOC_MANY && cnt_reg == '0) begin
                        state_next = S_DONE;
                    end else if (ptr_fix >= eff_total) begin
                        res_st_next  = ST_NO_SPACE;
                        res_rem_next = (act_reg == ACT_ALLOC_MANY) ? cnt_reg : '0;
                        state_next   = S_DONE;
                    end else begin
                        ram_re      = 1'b1;
                        ram_raddr   = ptr_fix[BLK_W-1:BIT_W];
                        w_next      = ptr_fix[BLK_W-1:BIT_W];
                        off_next    = ptr_fix[BIT_W-1:0];
                        remain_next = cnt_reg;
                        fresh_next  = 1'b1;
                        state_next  = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (scan.found) begin
                    // Grant one block per cycle while the output is free
                    if (out_free) begin
                        emit_valid  = 1'b1;
                        emit_blk    = grant_blk;
                        wrd_next    = grant_word;
                        fresh_next  = 1'b0;
                        remain_next = remain_reg - CNT_W'(1);
                        if (act_reg == ACT_ALLOC_MANY && remain_reg != CNT_W'(1)) begin
                            emit_last = 1'b0;
                        end else begin
                            ram_we     = 1'b1;
                            ram_wdata  = grant_word;
                            ptr_next   = {1'b0, grant_blk} + PTR_W'(1);
                            state_next = S_IDLE;
                        end
                    end
                end else begin
                    // Word exhausted: write it back and advance
                    ram_we = 1'b1;
                    if (next_base >= eff_total) begin
                        res_st_next  = ST_NO_SPACE;
                        res_rem_next = (act_reg == ACT_ALLOC_MANY) ? remain_reg : '0;
                        state_next   = S_DONE;
                    end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = w_reg + WORD_AW'(1);
                        w_next     = w_reg + WORD_AW'(1);
                        off_next   = '0;
                        fresh_next = 1'b1;
                    end
                end
            end

            S_OCC_LO: begin
                if (cnt_reg > MAX_REQUEST_C || occ_end >= eff_total) begin
                    res_st_next = ST_RANGE;
                    state_next  = S_DONE;
                end else begin
                    // Hold the low word, fetch the next one
                    wrd_next   = ram_q;
                    ram_re     = 1'b1;
                    ram_raddr  = blk_reg[BLK_W-1:BIT_W] + WORD_AW'(1);
                    state_next = S_OCC_HI;
                end
            end

            S_OCC_HI: begin
                if (|({ram_q, wrd_reg} & occ_mask)) begin
                    res_st_next = ST_CONFLICT;
                    state_next  = S_DONE;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = blk_reg[BLK_W-1:BIT_W];
                    ram_wdata  = wrd_reg | occ_mask[WORD_W-1:0];
                    state_next = S_OCC_WR;
                end
            end

            S_OCC_WR: begin
                ram_we     = |occ_mask[2*WORD_W-1:WORD_W];
                ram_waddr  = blk_reg[BLK_W-1:BIT_W] + WORD_AW'(1);
                ram_wdata  = ram_q | occ_mask[2*WORD_W-1:WORD_W];
                state_next = S_DONE;
            end

            S_DONE: begin
                // Send the closing result
                if (out_free) begin
                    emit_valid = 1'b1;
                    emit_used  = res_used_reg;
                    emit_st    = res_st_reg;
                    emit_rem   = res_rem_reg;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_valid) begin
            m_tdata_reg <= {{(OUT_DATA_W - OUT_REM_LSB - CNT_W){1'b0}},
                            emit_rem, emit_st, emit_used, emit_blk};
            m_tlast_reg <= emit_last;
        end
    end

endmodule

// ----- rtl/bba_checker.sv -----
module bba_checker
    import bba_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    logic fail_res;

    assign fail_res = m_tvalid && (m_tdata[OUT_ST_LSB +: ST_W] != ST_OK);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // One request at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // Any failure status closes the request
    a_fail_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fail_res |-> m_tlast)
        else $error("failure result not marked last");

    // Failures carry no block
    a_fail_blk: assert property (@(posedge aclk) disable iff (!aresetn)
        fail_res |-> (m_tdata[BLK_W-1:0] == '0))
        else $error("failure result carries a block");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
